/* hw/rtl/imc_pkg.sv */
// Shared types and constants for the index map injectivity checker.
// Holds the configuration struct, status codes and seen-store epoch sizing.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package imc_pkg;

    localparam int unsigned CFG_W   = 13;
    localparam int unsigned IDX_W   = 32;
    localparam int unsigned EPOCH_W = 8;

    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = '0;

    // Register indexes on the configuration port
    localparam logic REG_SLOT_COUNT = 1'b0;
    localparam logic REG_EDGE_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_COUNT = 2'd1,
        ST_MAP   = 2'd2
    } t_status;

    typedef struct packed {
        logic [CFG_W-1:0] slot_count;
        logic [CFG_W-1:0] edge_count;
    } t_cfg;

endpackage

`default_nettype wire

/* hw/rtl/imc_seen_ram.sv */
// Seen-mark store: one epoch tag per physical slot.
// Single write port, single read port, registered read data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module imc_seen_ram #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = 12,
    parameter int unsigned W     = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [W-1:0]  i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [W-1:0]  o_rd_data
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/imc_apb_regs.sv */
// APB-style configuration registers: slot_count and edge_count.
// Depends on imc_pkg for the configuration struct and register indexes.
`timescale 1ns / 1ps
`default_nettype none

module imc_apb_regs (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output imc_pkg::t_cfg    o_cfg
);

    imc_pkg::t_cfg r_cfg;
    logic          w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            if (paddr[2] == imc_pkg::REG_SLOT_COUNT) begin
                r_cfg.slot_count <= pwdata[imc_pkg::CFG_W-1:0];
            end else begin
                r_cfg.edge_count <= pwdata[imc_pkg::CFG_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == imc_pkg::REG_SLOT_COUNT) begin
            prdata = {{(32 - imc_pkg::CFG_W){1'b0}}, r_cfg.slot_count};
        end else begin
            prdata = {{(32 - imc_pkg::CFG_W){1'b0}}, r_cfg.edge_count};
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* hw/rtl/index_map_injectivity_check_core.sv */
// Top level of the index map injectivity checker.
// Uses imc_pkg, imc_apb_regs and imc_seen_ram.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one physical index per
//   beat; i_first opens a new map. Output channel (o_out_valid / i_out_ready)
//   returns one result beat per input beat: status, entries checked so far
//   and map-complete flag. Configure slot_count (byte address 0) and
//   edge_count (byte address 4) over the APB port while the block is idle.
// Pipeline and throughput:
//   An accepted input beat enters the check stage, and its seen-store read
//   is issued at the accepting edge; when the check stage moves on, the
//   check result lands in the output register and the mark is written back.
//   One beat per cycle is sustained while results are taken and no clearing
//   pass runs; back-to-back hits on the same slot are resolved by forwarding
//   the write in flight. Seen marks are epoch tags, so a new map costs
//   nothing, except that every 255th map waits for a clearing pass.
// Reset:
//   Control registers and counters are reset, the epoch to its first value;
//   a clearing pass then sweeps the seen store, with o_in_ready low throughout.
// Stall:
//   When i_out_ready is low the result holds in the output register; one
//   more beat can be taken into the check stage, after which o_in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module index_map_injectivity_check_core #(
    parameter int unsigned MAP_SLOTS = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_physical_index,
    input  wire logic        i_first,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [1:0]  o_status,
    output logic      [12:0] o_entries_checked,
    output logic             o_map_complete
);

    localparam int unsigned AW    = (MAP_SLOTS > 1) ? $clog2(MAP_SLOTS) : 1;
    localparam int unsigned EW    = imc_pkg::EPOCH_W;
    localparam int unsigned CW    = imc_pkg::CFG_W;
    localparam int unsigned XW    = imc_pkg::IDX_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_SLOTS - 1);
    localparam logic [XW-1:0] SLOTS_LIM = XW'(MAP_SLOTS);

    imc_pkg::t_cfg w_cfg;

    // clearing pass and epoch
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic [EW-1:0] r_epoch;
    logic          r_fresh;

    // check stage
    logic          r_s1_valid;
    logic [XW-1:0] r_s1_idx;
    logic          r_s1_first;
    logic [EW-1:0] r_s1_epoch;
    logic          r_s1_fwd_hit;
    logic [EW-1:0] r_s1_fwd_epoch;

    // map state
    logic [CW-1:0]    r_cnt;
    imc_pkg::t_status r_sticky;

    // output register
    logic             r_out_valid;
    imc_pkg::t_status r_out_status;
    logic [CW-1:0]    r_out_cnt;
    logic             r_out_complete;

    logic             w_in_fire;
    logic             w_wrap_stall;
    logic             w_s1_move;
    logic             w_count_err;
    logic [EW-1:0]    w_item_epoch;
    logic [EW-1:0]    w_rd_data;
    logic [EW-1:0]    w_mark;
    logic             w_seen;
    logic             w_in_range;
    logic             w_check;
    logic             w_bad;
    logic [CW-1:0]    w_base_cnt;
    imc_pkg::t_status w_base_st;
    logic [CW-1:0]    w_n_cnt;
    imc_pkg::t_status w_n_st;
    imc_pkg::t_status w_res_st;
    logic             w_mark_en;
    logic             w_ram_wr_en;
    logic [AW-1:0]    w_ram_wr_addr;
    logic [EW-1:0]    w_ram_wr_data;

    imc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    imc_seen_ram #(
        .DEPTH (MAP_SLOTS),
        .AW    (AW),
        .W     (EW)
    ) u_seen (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_wr_en),
        .i_wr_addr (w_ram_wr_addr),
        .i_wr_data (w_ram_wr_data),
        .i_rd_en   (w_in_fire),
        .i_rd_addr (i_physical_index[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    // handshake
    assign w_wrap_stall = i_in_valid && i_first && !r_fresh && (r_epoch == imc_pkg::EPOCH_MAX);
    assign w_s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready   = !r_clearing && !w_wrap_stall && (!r_s1_valid || w_s1_move);
    assign w_in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        if (i_first && !r_fresh) begin
            w_item_epoch = r_epoch + EW'(1);
        end else begin
            w_item_epoch = r_epoch;
        end
    end

    // check stage
    assign w_count_err = (w_cfg.edge_count > w_cfg.slot_count) ||
                         ({{(XW - CW){1'b0}}, w_cfg.slot_count} > SLOTS_LIM);
    assign w_base_cnt  = r_s1_first ? '0 : r_cnt;
    assign w_base_st   = r_s1_first ? imc_pkg::ST_OK : r_sticky;
    assign w_mark      = r_s1_fwd_hit ? r_s1_fwd_epoch : w_rd_data;
    assign w_seen      = (w_mark == r_s1_epoch);
    assign w_in_range  = r_s1_idx < {{(XW - CW){1'b0}}, w_cfg.slot_count};
    assign w_check     = !w_count_err && (w_base_st == imc_pkg::ST_OK) &&
                         (w_base_cnt < w_cfg.edge_count);
    assign w_bad       = !w_in_range || w_seen;
    assign w_n_st      = (w_check && w_bad) ? imc_pkg::ST_MAP : w_base_st;
    assign w_n_cnt     = (w_check && !w_bad) ? w_base_cnt + CW'(1) : w_base_cnt;
    assign w_res_st    = w_count_err ? imc_pkg::ST_COUNT : w_n_st;
    assign w_mark_en   = w_s1_move && w_check && !w_bad;

    // clearing pass owns the write port while it runs
    always_comb begin
        if (r_clearing) begin
            w_ram_wr_en   = 1'b1;
            w_ram_wr_addr = r_clr_addr;
            w_ram_wr_data = imc_pkg::EPOCH_CLEAR;
        end else begin
            w_ram_wr_en   = w_mark_en;
            w_ram_wr_addr = r_s1_idx[AW-1:0];
            w_ram_wr_data = r_s1_epoch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_epoch     <= imc_pkg::EPOCH_FIRST;
            r_fresh     <= 1'b1;
            r_s1_valid  <= 1'b0;
            r_cnt       <= '0;
            r_sticky    <= imc_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    r_clearing <= 1'b0;
                    r_epoch    <= imc_pkg::EPOCH_FIRST;
                    r_fresh    <= 1'b1;
                end
            end else if (w_wrap_stall && !r_s1_valid) begin
                // epochs exhausted: sweep the store before the new map
                r_clearing <= 1'b1;
                r_clr_addr <= '0;
            end

            if (w_in_fire) begin
                r_epoch <= w_item_epoch;
                r_fresh <= 1'b0;
            end

            if (w_in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end

            if (w_s1_move) begin
                r_cnt       <= w_n_cnt;
                r_sticky    <= w_n_st;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_idx       <= i_physical_index;
            r_s1_first     <= i_first;
            r_s1_epoch     <= w_item_epoch;
            // write landing in the same cycle as this read: forward it
            r_s1_fwd_hit   <= w_mark_en && (r_s1_idx[AW-1:0] == i_physical_index[AW-1:0]);
            r_s1_fwd_epoch <= r_s1_epoch;
        end
        if (w_s1_move) begin
            r_out_status   <= w_res_st;
            r_out_cnt      <= w_n_cnt;
            r_out_complete <= (w_res_st == imc_pkg::ST_OK) && (w_n_cnt >= w_cfg.edge_count);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_entries_checked = r_out_cnt;
    assign o_map_complete    = r_out_complete;

endmodule

`default_nettype wire

/* hw/rtl/imc_port_checker.sv */
// Port-level checks for index_map_injectivity_check_core, with its bind.
// Depends on imc_pkg for the status codes and on the top level's port list.
`timescale 1ns / 1ps
`default_nettype none

module imc_port_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  o_status,
    input wire logic [12:0] o_entries_checked,
    input wire logic        o_map_complete
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_entries_checked) &&
            $stable(o_map_complete))
        else $error("result beat changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat straight after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == imc_pkg::ST_OK) || (o_status == imc_pkg::ST_COUNT) ||
                        (o_status == imc_pkg::ST_MAP))
        else $error("undefined status code");

    a_complete_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_map_complete |-> o_status == imc_pkg::ST_OK)
        else $error("map complete with error status");

endmodule

bind index_map_injectivity_check_core imc_port_checker u_port_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_status          (o_status),
    .o_entries_checked (o_entries_checked),
    .o_map_complete    (o_map_complete)
);

`default_nettype wire
